@@ hdl/hermite_fractional_delay_line_top_macros.svh @@
// Assertion macros used by the delay line checker.
`ifndef HERMITE_FRACTIONAL_DELAY_LINE_TOP_MACROS_SVH
`define HERMITE_FRACTIONAL_DELAY_LINE_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define HFDL_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Check the consequent in the cycle after the antecedent.
`define HFDL_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

@@ hdl/hfdl_pkg.sv @@
// Shared constants, codes and state types of the fractional delay line.
`default_nettype none

package hfdl_pkg;

  localparam int unsigned STORE_DEPTH_DEF   = 131072;
  localparam int unsigned SAMPLE_BITS_DEF   = 24;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned ACTION_W       = 2;
  localparam int unsigned CFG_W          = 18;
  localparam int unsigned RAW_INDEX_W    = 17;
  localparam int unsigned DELAY_INT_BITS = 17;
  localparam int unsigned LEN_MIN        = 4;
  localparam int unsigned FETCH_TAPS     = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_INTERP = 2'd1,
    ACT_RAW    = 2'd2,
    ACT_CLEAR  = 2'd3
  } hfdl_action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_BASE,
    ST_FETCH,
    ST_CALC,
    ST_RAW,
    ST_DONE
  } hfdl_state_t;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_COEF,
    STEP_M1,
    STEP_A1,
    STEP_M2,
    STEP_A2,
    STEP_M3,
    STEP_A3
  } hfdl_step_t;

endpackage

`default_nettype wire

@@ hdl/hfdl_interp.sv @@
// Four-point Hermite interpolator: Horner chain on one shared multiplier.
`default_nettype none

module hfdl_interp #(
  parameter int unsigned SAMPLE_BITS   = hfdl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = hfdl_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [SAMPLE_BITS-1:0]   samp_a,
  input  logic signed [SAMPLE_BITS-1:0]   samp_b,
  input  logic signed [SAMPLE_BITS-1:0]   samp_c,
  input  logic signed [SAMPLE_BITS-1:0]   samp_d,
  input  logic        [FRACTION_BITS-1:0] frac,
  output logic                            done,
  output logic signed [SAMPLE_BITS-1:0]   result
);
  import hfdl_pkg::*;

  localparam int unsigned CW = SAMPLE_BITS + 4;
  localparam int unsigned TW = SAMPLE_BITS + 6;
  localparam int unsigned PW = SAMPLE_BITS + FRACTION_BITS + 7;
  localparam int unsigned RW = PW - FRACTION_BITS - 1;

  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [PW-1:0] RND_ONE  = PW'(1) <<< FRACTION_BITS;
  localparam logic signed [RW-1:0] SAT_MAX  = RW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_MIN  = ~SAT_MAX;

  hfdl_step_t step_r, step_nxt;
  logic       done_r, done_nxt;

  logic signed [CW-1:0]          a2_r, a2_nxt;
  logic signed [CW-1:0]          b2_r, b2_nxt;
  logic signed [CW-1:0]          s2_r, s2_nxt;
  logic signed [TW-1:0]          t_r, t_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;

  logic signed [CW-1:0]            ea, eb, ec, ed;
  logic signed [TW-1:0]            mul_op;
  logic signed [FRACTION_BITS:0]   frac_s;
  logic signed [PW-1:0]            prod_c;
  logic signed [PW-1:0]            acc;
  logic signed [RW-1:0]            rnd;

  assign ea     = CW'(samp_a);
  assign eb     = CW'(samp_b);
  assign ec     = CW'(samp_c);
  assign ed     = CW'(samp_d);
  assign frac_s = {1'b0, frac};

  // One multiplier serves all three Horner steps.
  assign mul_op = (step_r == STEP_M1) ? TW'(a2_r) : t_r;
  assign prod_c = PW'(mul_op) * PW'(frac_s);

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    a2_nxt   = a2_r;
    b2_nxt   = b2_r;
    s2_nxt   = s2_r;
    t_nxt    = t_r;
    prod_nxt = prod_r;
    res_nxt  = res_r;
    acc      = '0;
    rnd      = '0;
    case (step_r)
      STEP_IDLE: begin
        if (start) begin
          step_nxt = STEP_COEF;
        end
      end
      STEP_COEF: begin
        // twice the cubic coefficients, the quadratic one negated
        a2_nxt   = ed - ea + (eb - ec) + ((eb - ec) <<< 1);
        b2_nxt   = ed - (ea <<< 1) + (eb <<< 2) + eb - (ec <<< 2);
        s2_nxt   = ec - ea;
        step_nxt = STEP_M1;
      end
      STEP_M1: begin
        prod_nxt = prod_c;
        step_nxt = STEP_A1;
      end
      STEP_A1: begin
        acc      = prod_r - (PW'(b2_r) <<< FRACTION_BITS) + RND_HALF;
        t_nxt    = TW'(acc >>> FRACTION_BITS);
        step_nxt = STEP_M2;
      end
      STEP_M2: begin
        prod_nxt = prod_c;
        step_nxt = STEP_A2;
      end
      STEP_A2: begin
        acc      = prod_r + (PW'(s2_r) <<< FRACTION_BITS) + RND_HALF;
        t_nxt    = TW'(acc >>> FRACTION_BITS);
        step_nxt = STEP_M3;
      end
      STEP_M3: begin
        prod_nxt = prod_c;
        step_nxt = STEP_A3;
      end
      STEP_A3: begin
        acc = prod_r + (PW'(samp_b) <<< (FRACTION_BITS + 1)) + RND_ONE;
        rnd = RW'(acc >>> (FRACTION_BITS + 1));
        if (rnd > SAT_MAX) begin
          res_nxt = SAMPLE_BITS'(SAT_MAX);
        end else if (rnd < SAT_MIN) begin
          res_nxt = SAMPLE_BITS'(SAT_MIN);
        end else begin
          res_nxt = SAMPLE_BITS'(rnd);
        end
        done_nxt = 1'b1;
        step_nxt = STEP_IDLE;
      end
      default: begin
        step_nxt = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    s2_r   <= s2_nxt;
    t_r    <= t_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

@@ hdl/hermite_fractional_delay_line_top.sv @@
// Top level of the fractional delay line with four-point Hermite interpolation.
//
// A circular store of STORE_DEPTH signed Q1.23 samples, held in one single-port
// synchronous memory, serves four actions. A write advances the write position
// (wrapping to zero at line_length) and stores the sample there. An
// interpolated read saturates the Q17.16 delay to [1, line_length-2], fetches
// the four neighbours around the write position minus the integer delay and
// returns the cubic Hermite value at the fraction. A raw read returns one
// entry (zero when the index is not below line_length). A clear zeroes the
// store and sets the write position to line_length-1. Every accepted word
// gives exactly one result word; writes and clears return zero. The input is
// accepted only in idle, one word at a time. An interpolated read makes four
// reads through the one memory port, then the three multiply and round steps
// of the Horner chain, preceded by restoring remainder steps when line_length
// was lowered to or below the write position. After reset and after every
// clear the memory is swept to zero, one entry per cycle, over all STORE_DEPTH
// entries with in_stall high; the clear's result word follows the sweep. A
// finished result sits in the output register while the next word is taken
// in. line_length is written through the cfg port, always ready; the user must
// write it only while the block is idle, which the block itself does not
// enforce. Values below 4 or above STORE_DEPTH are clamped.
`default_nettype none

module hermite_fractional_delay_line_top #(
  parameter int unsigned STORE_DEPTH   = hfdl_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = hfdl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = hfdl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  output logic                                                 in_stall,
  input  logic [hfdl_pkg::ACTION_W-1:0]                        in_action,
  input  logic signed [SAMPLE_BITS-1:0]                        in_sample_in,
  input  logic [hfdl_pkg::DELAY_INT_BITS+FRACTION_BITS-1:0]    in_delay,
  input  logic [hfdl_pkg::RAW_INDEX_W-1:0]                     in_raw_index,
  output logic                                                 out_valid,
  input  logic                                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]                        out_sample_out,
  input  logic                                                 cfg_valid,
  output logic                                                 cfg_ready,
  input  logic [hfdl_pkg::CFG_W-1:0]                           cfg_data
);
  import hfdl_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LEN_X   = LEN_W + 1;
  localparam int unsigned DELAY_W = DELAY_INT_BITS + FRACTION_BITS;
  localparam int unsigned CMP_W   = (DELAY_W > LEN_W + FRACTION_BITS) ?
                                    DELAY_W : LEN_W + FRACTION_BITS;
  localparam int unsigned CL_W    = (CFG_W > LEN_W) ? CFG_W : LEN_W;
  localparam int unsigned RI_W    = (RAW_INDEX_W > LEN_W) ? RAW_INDEX_W : LEN_W;
  localparam int unsigned MOD_W   = ADDR_W + LEN_W;
  localparam int unsigned KW      = $clog2(ADDR_W);
  localparam int unsigned XW      = LEN_W + 2;
  localparam int unsigned FC_W    = $clog2(FETCH_TAPS + 1);

  // ---------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------
  hfdl_state_t             state_r, state_nxt;
  logic [LEN_W-1:0]        len_r;
  logic [ADDR_W-1:0]       wp_r, wp_nxt;
  logic [ADDR_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                    clr_res_r, clr_res_nxt;
  logic [KW-1:0]           mod_k_r, mod_k_nxt;
  logic [FC_W-1:0]         fetch_cnt_r, fetch_cnt_nxt;
  logic                    start_r, start_nxt;
  logic                    out_valid_r;

  logic [LEN_W-1:0]             d_r, d_nxt;
  logic [FRACTION_BITS-1:0]     frac_r, frac_nxt;
  logic [ADDR_W-1:0]            rem_r, rem_nxt;
  logic [ADDR_W-1:0]            addr_r, addr_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic signed [SAMPLE_BITS-1:0] samp_r [FETCH_TAPS];

  // Sample store and its registered read port
  logic signed [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_q_r;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_addr;
  logic signed [SAMPLE_BITS-1:0] mem_wdata;

  // Combinational helpers
  logic [CL_W-1:0]          cfg_val;
  logic [LEN_W-1:0]         len_cfg;
  logic [CMP_W-1:0]         dly_ext, dly_lo, dly_hi;
  logic [LEN_W-1:0]         d_cl;
  logic [FRACTION_BITS-1:0] f_cl;
  logic [LEN_X-1:0]         wp_inc;
  logic [ADDR_W-1:0]        wp_next;
  logic                     wp_beyond;
  logic                     raw_ok;
  logic [MOD_W-1:0]         mod_sub;
  logic [XW-1:0]            base_x, base_w;
  logic                     in_take;
  logic                     samp_shift;
  logic                     out_load;
  logic                     calc_done;
  logic signed [SAMPLE_BITS-1:0] calc_res;

  // ---------------------------------------------------------------------
  // Configuration: clamp line_length into [4, STORE_DEPTH]
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_val = CL_W'(cfg_data);
    if (cfg_val < CL_W'(LEN_MIN)) begin
      cfg_val = CL_W'(LEN_MIN);
    end else if (cfg_val > CL_W'(STORE_DEPTH)) begin
      cfg_val = CL_W'(STORE_DEPTH);
    end
    len_cfg = LEN_W'(cfg_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(STORE_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= len_cfg;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  // Saturate the delay to [1.0, line_length-2]; out-of-range delays lose
  // their fraction.
  always_comb begin
    dly_ext = CMP_W'(in_delay);
    dly_lo  = CMP_W'(1) << FRACTION_BITS;
    dly_hi  = CMP_W'(len_r - LEN_W'(2)) << FRACTION_BITS;
    if (dly_ext < dly_lo) begin
      d_cl = LEN_W'(1);
      f_cl = '0;
    end else if (dly_ext > dly_hi) begin
      d_cl = len_r - LEN_W'(2);
      f_cl = '0;
    end else begin
      d_cl = LEN_W'(dly_ext >> FRACTION_BITS);
      f_cl = in_delay[FRACTION_BITS-1:0];
    end
  end

  // Next write position; a position left beyond a lowered length wraps to 0.
  assign wp_inc    = LEN_X'(wp_r) + LEN_X'(1);
  assign wp_next   = (wp_inc >= LEN_X'(len_r)) ? '0 : ADDR_W'(wp_inc);
  assign wp_beyond = (LEN_W'(wp_r) >= len_r);
  assign raw_ok    = (RI_W'(in_raw_index) < RI_W'(len_r));

  // One restoring remainder step: subtract line_length << k when it fits.
  assign mod_sub = MOD_W'(len_r) << mod_k_r;

  // Newest tap index: position + 1 - delay, wrapped once when negative.
  assign base_x = XW'(rem_r) + XW'(1) - XW'(d_r);
  assign base_w = base_x[XW-1] ? (base_x + XW'(len_r)) : base_x;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------
  // Sequencer: next state, memory port and payload updates
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_res_nxt   = clr_res_r;
    mod_k_nxt     = mod_k_r;
    fetch_cnt_nxt = fetch_cnt_r;
    start_nxt     = 1'b0;
    d_nxt         = d_r;
    frac_nxt      = frac_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_addr      = addr_r;
    mem_wdata     = in_sample_in;
    samp_shift    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // zero one entry per cycle over the whole store
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_res_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          case (hfdl_action_t'(in_action))
            ACT_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = wp_next;
              mem_wdata = in_sample_in;
              wp_nxt    = wp_next;
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
            ACT_INTERP: begin
              d_nxt    = d_cl;
              frac_nxt = f_cl;
              rem_nxt  = wp_r;
              if (wp_beyond) begin
                mod_k_nxt = KW'(ADDR_W - 1);
                state_nxt = ST_MOD;
              end else begin
                state_nxt = ST_BASE;
              end
            end
            ACT_RAW: begin
              res_nxt = '0;
              if (raw_ok) begin
                mem_addr  = ADDR_W'(in_raw_index);
                state_nxt = ST_RAW;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            ACT_CLEAR: begin
              wp_nxt      = ADDR_W'(len_r - LEN_W'(1));
              clr_cnt_nxt = '0;
              clr_res_nxt = 1'b1;
              res_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_MOD: begin
        if (MOD_W'(rem_r) >= mod_sub) begin
          rem_nxt = ADDR_W'(MOD_W'(rem_r) - mod_sub);
        end
        mod_k_nxt = mod_k_r - KW'(1);
        if (mod_k_r == '0) begin
          state_nxt = ST_BASE;
        end
      end

      ST_BASE: begin
        addr_nxt      = ADDR_W'(base_w);
        fetch_cnt_nxt = '0;
        state_nxt     = ST_FETCH;
      end

      ST_FETCH: begin
        // issue A, B, C, D newest first; data lands in the cycle after
        mem_addr = addr_r;
        if (fetch_cnt_r != '0) begin
          samp_shift = 1'b1;
        end
        if (fetch_cnt_r == FC_W'(FETCH_TAPS)) begin
          start_nxt = 1'b1;
          state_nxt = ST_CALC;
        end else begin
          addr_nxt      = (addr_r == '0) ? ADDR_W'(len_r - LEN_W'(1))
                                         : addr_r - ADDR_W'(1);
          fetch_cnt_nxt = fetch_cnt_r + FC_W'(1);
        end
      end

      ST_CALC: begin
        if (calc_done) begin
          res_nxt   = calc_res;
          state_nxt = ST_DONE;
        end
      end

      ST_RAW: begin
        res_nxt   = rd_q_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wp_r        <= ADDR_W'(STORE_DEPTH - 1);
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      mod_k_r     <= '0;
      fetch_cnt_r <= '0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_res_r   <= clr_res_nxt;
      mod_k_r     <= mod_k_nxt;
      fetch_cnt_r <= fetch_cnt_nxt;
      start_r     <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    frac_r <= frac_nxt;
    rem_r  <= rem_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
  end

  // Tap line: A ends in slot 0, D in slot 3.
  always_ff @(posedge clk) begin
    if (samp_shift) begin
      for (int i = 0; i < FETCH_TAPS - 1; i++) begin
        samp_r[i] <= samp_r[i+1];
      end
      samp_r[FETCH_TAPS-1] <= rd_q_r;
    end
  end

  // ---------------------------------------------------------------------
  // Sample store: single port, registered read. Writes only happen in idle
  // or during the sweep and reads only afterwards, so no access overlaps.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end else begin
      rd_q_r <= store_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Interpolator
  // ---------------------------------------------------------------------
  hfdl_interp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .samp_a (samp_r[0]),
    .samp_b (samp_r[1]),
    .samp_c (samp_r[2]),
    .samp_d (samp_r[3]),
    .frac   (frac_r),
    .done   (calc_done),
    .result (calc_res)
  );

  // ---------------------------------------------------------------------
  // Output register: refill when empty or when the held word is taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

`default_nettype wire

@@ hdl/hfdl_checker.sv @@
// Port-level checker for the delay line and its bind to the top level.
`default_nettype none

`include "hermite_fractional_delay_line_top_macros.svh"

module hfdl_checker #(
  parameter int unsigned SAMPLE_BITS = hfdl_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out
);

  // a stalled result word stays put
  `HFDL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sample_out), "result word changed under stall")

  // the clearing sweep after reset keeps the input closed
  `HFDL_ASSERT_SAME(a_sweep_after_reset, clk, rst_n, $rose(rst_n), in_stall, "input open during reset sweep")

  // one word at a time: an accepted word closes the input
  `HFDL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

  // a new result appears only as the block returns to idle
  `HFDL_ASSERT_SAME(a_result_at_idle, clk, rst_n, $rose(out_valid), !in_stall, "result raised while still busy")

endmodule

bind hermite_fractional_delay_line_top hfdl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_hfdl_checker (.*);

`default_nettype wire
